// ===== rtl/matrix_vector_mac_defines.svh =====
// ----------------------------------------------------------------------------
// matrix_vector_mac_defines
// Assertion macros used by the matrix-vector MAC top module.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MAC_DEFINES_SVH
`define MATRIX_VECTOR_MAC_DEFINES_SVH

// same-cycle implication
`define MVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Fixed widths and constants of the matrix-vector MAC.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // port field widths
    localparam int IDX_W       = 10;
    localparam int SIZE_REG_W  = 11;
    localparam int VAL_PORT_W  = 16;
    localparam int SUM_W       = 48;

    // size register value after reset
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;

    // saturation limits of a running sum
    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    // request kinds
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_MAC  = 1'b1
    } t_mode;

endpackage

// ===== rtl/matrix_vector_mac.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_mac
// Streaming y = A * x: load requests store x[c] and clear y[c]; matrix
// requests add a * x[c] into y[r] with 48-bit saturation and emit y[r].
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_mode, i_row_index,
//                                               i_column_index, i_element_value
//  result    out        o_valid / i_ready       o_result_row, o_running_sum,
//                                               o_saturated
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (size in use)
//
//  One request per cycle; its valid moves through each stage to o_valid.
//  Stages: memory read, multiply, add/saturate with sum write-back; sums
//  still in flight are forwarded, so the sum read-modify-write sets the rate.
//  Stores hold no value after reset; nothing is cleared, the block is ready
//  at once. A result held on the output stalls the whole pipeline.
`include "matrix_vector_mac_defines.svh"

module matrix_vector_mac #(
    parameter int SIZE       = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mvm_pkg::SIZE_REG_W-1:0]         i_cfg_data,
    // requests
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_mode,
    input  logic [mvm_pkg::IDX_W-1:0]              i_row_index,
    input  logic [mvm_pkg::IDX_W-1:0]              i_column_index,
    input  logic signed [mvm_pkg::VAL_PORT_W-1:0]  i_element_value,
    // results
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [mvm_pkg::IDX_W-1:0]              o_result_row,
    output logic signed [mvm_pkg::SUM_W-1:0]       o_running_sum,
    output logic                                   o_saturated
);
    import mvm_pkg::*;

    localparam int ADDR_W = $clog2(SIZE);
    localparam int EV_W   = (VALUE_BITS > VAL_PORT_W) ? VALUE_BITS : VAL_PORT_W;
    localparam int PROD_W = 2 * VALUE_BITS;
    localparam int FULL_W = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    // size register
    logic [SIZE_REG_W-1:0] r_size;

    // stage 0 decode
    logic                    adv;
    logic                    acc;
    logic                    col_ok;
    logic                    row_ok;
    logic                    s0_ok;
    logic                    s0_is_mac;
    logic [EV_W-1:0]         ev_ext;
    logic signed [VALUE_BITS-1:0] s0_val;
    logic [ADDR_W-1:0]       s0_col;
    logic [ADDR_W-1:0]       s0_addr;

    // vector store
    logic signed [VALUE_BITS-1:0] r_vec [SIZE];
    logic signed [VALUE_BITS-1:0] r_vec_rd;

    // stage 1
    logic                         r_s1_valid;
    t_mode                        r_s1_mode;
    logic [ADDR_W-1:0]            r_s1_addr;
    logic signed [VALUE_BITS-1:0] r_s1_val;
    logic signed [SUM_W-1:0]      s1_base;

    // stage 2
    logic                         r_s2_valid;
    t_mode                        r_s2_mode;
    logic [ADDR_W-1:0]            r_s2_addr;
    logic signed [PROD_W-1:0]     r_s2_prod;
    logic signed [SUM_W-1:0]      r_s2_base;
    logic signed [FULL_W-1:0]     full;
    logic [FULL_W-SUM_W:0]        hi;
    logic                         ovf;
    logic signed [SUM_W-1:0]      sat_sum;
    logic                         s2_we;
    logic signed [SUM_W-1:0]      s2_wdata;

    // output register
    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_row;
    logic signed [SUM_W-1:0]      r_out_sum;
    logic                         r_out_sat;

    // pipeline moves as one while the output register can take a result
    assign adv     = !r_out_valid || i_ready;
    assign o_ready = adv;
    assign acc     = i_valid && adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    // range checks against the clipped size
    assign col_ok = ({1'b0, i_column_index} < r_size) && (32'(i_column_index) < 32'(SIZE));
    assign row_ok = ({1'b0, i_row_index} < r_size) && (32'(i_row_index) < 32'(SIZE));
    assign s0_is_mac = (t_mode'(i_mode) == MODE_MAC);
    assign s0_ok     = col_ok && (!s0_is_mac || row_ok);

    // element: low VALUE_BITS of the port field, two's complement
    assign ev_ext  = EV_W'($unsigned(i_element_value));
    assign s0_val  = $signed(ev_ext[VALUE_BITS-1:0]);
    assign s0_col  = ADDR_W'(i_column_index);
    assign s0_addr = s0_is_mac ? ADDR_W'(i_row_index) : s0_col;

    // vector store: loads write, matrix requests read
    always_ff @(posedge i_clk) begin
        if (acc && s0_ok && !s0_is_mac) begin
            r_vec[s0_col] <= s0_val;
        end
        if (acc && s0_ok && s0_is_mac) begin
            r_vec_rd <= r_vec[s0_col];
        end
    end

    // sum store, read at stage 0, written at stage 2
    mvm_sum_bank #(
        .SIZE   (SIZE),
        .ADDR_W (ADDR_W)
    ) u_sum_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (acc && s0_ok && s0_is_mac),
        .i_raddr (s0_addr),
        .i_we    (s2_we),
        .i_waddr (r_s2_addr),
        .i_wdata (s2_wdata),
        .o_rdata (s1_base)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= acc && s0_ok;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && (r_s2_mode == MODE_MAC);
        end
    end

    // stage payloads; stage 1 multiplies, base takes the write ahead of it
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode <= t_mode'(i_mode);
            r_s1_addr <= s0_addr;
            r_s1_val  <= s0_val;
            r_s2_mode <= r_s1_mode;
            r_s2_addr <= r_s1_addr;
            r_s2_prod <= PROD_W'(r_vec_rd) * PROD_W'(r_s1_val);
            r_s2_base <= (s2_we && (r_s2_addr == r_s1_addr)) ? s2_wdata : s1_base;
        end
    end

    // stage 2: add and saturate
    assign full    = FULL_W'(r_s2_base) + FULL_W'(r_s2_prod);
    assign hi      = full[FULL_W-1:SUM_W-1];
    assign ovf     = !((&hi) || !(|hi));
    assign sat_sum = ovf ? (full[FULL_W-1] ? SUM_MIN : SUM_MAX) : full[SUM_W-1:0];

    // write-back: new sum for matrix requests, zero for loads
    assign s2_we    = adv && r_s2_valid;
    assign s2_wdata = (r_s2_mode == MODE_MAC) ? sat_sum : '0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_row <= IDX_W'(r_s2_addr);
            r_out_sum <= sat_sum;
            r_out_sat <= ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_row  = r_out_row;
    assign o_running_sum = r_out_sum;
    assign o_saturated   = r_out_sat;

    // checks
    `MVM_ASSERT_IMP(a_sat_at_limit, i_clk, i_rst_n, o_valid && o_saturated,
        (o_running_sum == SUM_MAX) || (o_running_sum == SUM_MIN), "saturated sum off limit")
    `MVM_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_ready,
        !o_ready, "request taken while result held")
    `MVM_ASSERT_NXT(a_out_of_range_dropped, i_clk, i_rst_n, acc && !col_ok,
        !r_s1_valid, "out-of-range request entered pipeline")
    `MVM_ASSERT_NXT(a_load_no_result, i_clk, i_rst_n,
        adv && r_s2_valid && (r_s2_mode == MODE_LOAD), !o_valid, "load produced a result")

endmodule

// ===== rtl/mvm_sum_bank.sv =====
// ----------------------------------------------------------------------------
// mvm_sum_bank
// Running-sum memory: one write port, one registered read port, with the
// same-edge write forwarded into the read result.
// ----------------------------------------------------------------------------
module mvm_sum_bank #(
    parameter int SIZE   = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_re,
    input  logic [ADDR_W-1:0]                 i_raddr,
    input  logic                              i_we,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic signed [mvm_pkg::SUM_W-1:0]  i_wdata,
    output logic signed [mvm_pkg::SUM_W-1:0]  o_rdata
);
    import mvm_pkg::*;

    logic signed [SUM_W-1:0] r_mem [SIZE];
    logic signed [SUM_W-1:0] r_rd;
    logic signed [SUM_W-1:0] r_fwd_data;
    logic                    r_fwd_hit;

    // storage array, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd       <= r_mem[i_raddr];
            r_fwd_data <= i_wdata;
        end
    end

    // write landing on the address being read at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_re) begin
            r_fwd_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rd;

endmodule
